>>> rtl/core/fill_color_format_packer_core_assert.svh
// Assertion macros shared by the fill color packer RTL.
`ifndef FILL_COLOR_FORMAT_PACKER_CORE_ASSERT_SVH
`define FILL_COLOR_FORMAT_PACKER_CORE_ASSERT_SVH

// Plain property checked at every clock edge outside reset.
`define FCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Delayed implication: cause is followed by effect.
`define FCP_ASSERT_LAT(lbl, clk, rst_n, cause, n, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cause) |-> ##(n) (effect)) else $error(msg);

`endif

>>> rtl/core/fcfp_pkg.sv
// Types, codes and format helpers for the fill color packer.
`default_nettype none
package fcfp_pkg;

  localparam logic [3:0] TYPE_U8      = 4'd0;
  localparam logic [3:0] TYPE_U16     = 4'd1;
  localparam logic [3:0] TYPE_S8      = 4'd2;
  localparam logic [3:0] TYPE_S16     = 4'd3;
  localparam logic [3:0] TYPE_FLOAT   = 4'd4;
  localparam logic [3:0] TYPE_U32     = 4'd5;
  localparam logic [3:0] TYPE_S32     = 4'd6;
  localparam logic [3:0] TYPE_UNORM8  = 4'd7;
  localparam logic [3:0] TYPE_UNORM16 = 4'd8;
  localparam logic [3:0] TYPE_SNORM8  = 4'd9;
  localparam logic [3:0] TYPE_SNORM16 = 4'd10;
  localparam logic [3:0] TYPE_HALF    = 4'd11;
  localparam logic [3:0] TYPE_P565    = 4'd12;
  localparam logic [3:0] TYPE_P555    = 4'd13;
  localparam logic [3:0] TYPE_P101010 = 4'd14;
  localparam logic [3:0] TYPE_UNUSED  = 4'd15;

  localparam logic [2:0] ORDER_R     = 3'd0;
  localparam logic [2:0] ORDER_RG    = 3'd1;
  localparam logic [2:0] ORDER_RGB   = 3'd2;
  localparam logic [2:0] ORDER_RGBA  = 3'd3;
  localparam logic [2:0] ORDER_LUM   = 3'd4;
  localparam logic [2:0] ORDER_INT   = 3'd5;
  localparam logic [2:0] ORDER_BGRA  = 3'd6;
  localparam logic [2:0] ORDER_P2    = 3'd7;

  localparam logic [0:0] REG_DATA_TYPE = 1'd0;
  localparam logic [0:0] REG_ORDER     = 1'd1;

  // normalized channel classes
  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_FULL = 2'd1;
  localparam logic [1:0] CLS_CALC = 2'd2;

  typedef struct packed {
    logic [31:0] channel_word_0;
    logic [31:0] channel_word_1;
    logic [31:0] channel_word_2;
    logic [31:0] channel_word_3;
  } in_word_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [4:0]  pattern_bytes;
    logic        bad_format;
  } out_word_t;

  typedef struct packed {
    logic       bad;
    logic [2:0] csize;
    logic [2:0] nch;
    logic [4:0] nbytes;
  } fmt_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [3:0]  lg;     // floor(log2(scale))
    logic        snorm;
  } scale_t;

  function automatic fmt_t decode_fmt(logic [3:0] t, logic [2:0] o);
    fmt_t f;
    f = '{bad: 1'b0, csize: 3'd1, nch: 3'd1, nbytes: 5'd1};
    if (t == TYPE_UNUSED) begin
      f.bad = 1'b1;
    end else if (t >= TYPE_P565) begin
      if (o == ORDER_P2 && t == TYPE_P101010) f.csize = 3'd4;
      else if (o != ORDER_RGB) f.bad = 1'b1;
      else if (t == TYPE_P101010) f.csize = 3'd4;
      else f.csize = 3'd2;
    end else if (o == ORDER_P2) begin
      f.bad = 1'b1;
    end else begin
      case (o)
        ORDER_RG:               f.nch = 3'd2;
        ORDER_RGB:              f.nch = 3'd3;
        ORDER_RGBA, ORDER_BGRA: f.nch = 3'd4;
        default:                f.nch = 3'd1;
      endcase
      case (t)
        TYPE_U8, TYPE_S8, TYPE_UNORM8, TYPE_SNORM8: f.csize = 3'd1;
        TYPE_U16, TYPE_S16, TYPE_UNORM16, TYPE_SNORM16, TYPE_HALF: f.csize = 3'd2;
        default: f.csize = 3'd4;
      endcase
    end
    if (!f.bad) f.nbytes = 5'(f.nch) * 5'(f.csize);
    return f;
  endfunction

  function automatic scale_t scale_of(logic [3:0] t, logic [2:0] o, logic [1:0] idx);
    scale_t s;
    s = '{scale: 16'd1, lg: 4'd0, snorm: 1'b0};
    case (t)
      TYPE_UNORM8:  s = '{scale: 16'd255,   lg: 4'd7,  snorm: 1'b0};
      TYPE_UNORM16: s = '{scale: 16'd65535, lg: 4'd15, snorm: 1'b0};
      TYPE_SNORM8:  s = '{scale: 16'd127,   lg: 4'd6,  snorm: 1'b1};
      TYPE_SNORM16: s = '{scale: 16'd32767, lg: 4'd14, snorm: 1'b1};
      TYPE_P565: begin
        if (idx == 2'd1) s = '{scale: 16'd63, lg: 4'd5, snorm: 1'b0};
        else s = '{scale: 16'd31, lg: 4'd4, snorm: 1'b0};
      end
      TYPE_P555: s = '{scale: 16'd31, lg: 4'd4, snorm: 1'b0};
      TYPE_P101010: begin
        if (o == ORDER_P2 && idx == 2'd3) s = '{scale: 16'd3, lg: 4'd1, snorm: 1'b0};
        else s = '{scale: 16'd1023, lg: 4'd9, snorm: 1'b0};
      end
      default: s = '{scale: 16'd1, lg: 4'd0, snorm: 1'b0};
    endcase
    return s;
  endfunction

  // IEEE single to half, round to nearest even
  function automatic logic [15:0] half_of(logic [31:0] b);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [24:0] full;
    logic [4:0]  sh;
    logic [24:0] q;
    logic [24:0] r;
    logic [24:0] mid;
    logic [15:0] res;
    s    = b[31];
    e    = b[30:23];
    m    = b[22:0];
    full = {2'b01, m};
    sh   = (e >= 8'd113) ? 5'd13 : 5'(8'd126 - e);
    q    = full >> sh;
    r    = full & ((25'd1 << sh) - 25'd1);
    mid  = 25'd1 << (sh - 5'd1);
    if (r > mid || (r == mid && q[0])) q = q + 25'd1;
    if (e == 8'hFF) begin
      res = (m != 23'd0) ? ({s, 15'h7E00} | {6'd0, m[22:13]}) : {s, 15'h7C00};
    end else if (e == 8'd0) begin
      res = {s, 15'd0};
    end else if (e > 8'd142) begin
      res = {s, 15'h7C00};
    end else if (e >= 8'd113) begin
      res = {s, 15'({5'(e - 8'd113), 10'd0} + 15'(q))};
    end else if (e < 8'd102) begin
      res = {s, 15'd0};
    end else begin
      res = {s, 15'(q)};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fill_color_format_packer_core.sv
// Top level of the fill color packer: four-stage conversion pipeline.
`default_nettype none
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  input   | start, busy, in_word                    | taken when start && !busy
//  result  | out_valid, out_result                   | one-cycle strobe
//  config  | cfg_we, cfg_index, cfg_wdata            | write on cfg_we
//
// A word taken into stage A passes through B and C and is driven on out_result from the output register.
// One word per cycle, every cycle: busy stays low, nothing stalls.
// Stage A holds the input and a config snapshot, B holds the 24x16 products
// and half values, C holds the rounded products, the output register packs.
// rst_n (synchronous) clears valid bits and config; data registers are not reset.
module fill_color_format_packer_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire fcfp_pkg::in_word_t in_word,
  output      logic              out_valid,
  output fcfp_pkg::out_word_t    out_result,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [3:0]        cfg_wdata
);
  import fcfp_pkg::*;

  logic [3:0] type_r;
  logic [2:0] order_r;

  // stage A
  logic        a_vld_r;
  logic [31:0] a_word_r [4];
  logic [3:0]  a_type_r;
  logic [2:0]  a_order_r;
  // stage B
  logic        b_vld_r;
  logic [31:0] b_word_r [4];
  logic [39:0] b_prod_r [4];
  logic [7:0]  b_exp_r  [4];
  logic [1:0]  b_cls_r  [4];
  logic        b_neg_r  [4];
  logic [15:0] b_half_r [4];
  logic [15:0] b_scale_r[4];
  logic [3:0]  b_lg_r   [4];
  logic [3:0]  b_type_r;
  logic [2:0]  b_order_r;
  // stage C
  logic        c_vld_r;
  logic [31:0] c_word_r [4];
  logic [24:0] c_q_r    [4];
  logic [8:0]  c_sh_r   [4];
  logic [1:0]  c_cls_r  [4];
  logic        c_neg_r  [4];
  logic [15:0] c_half_r [4];
  logic [15:0] c_scale_r[4];
  logic [3:0]  c_type_r;
  logic [2:0]  c_order_r;
  // output
  logic        out_vld_r;
  out_word_t   out_r;
  out_word_t   out_nxt;

  assign busy       = 1'b0;
  assign out_valid  = out_vld_r;
  assign out_result = out_r;

  // configuration and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r    <= TYPE_U8;
      order_r   <= ORDER_RGBA;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_DATA_TYPE) type_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_ORDER) order_r <= cfg_wdata[2:0];
      a_vld_r   <= start && !busy;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      out_vld_r <= c_vld_r;
    end
  end

  // stage A: capture the word with the format it was taken under, and carry that format on through B and C
  always_ff @(posedge clk) begin
    a_word_r[0] <= in_word.channel_word_0;
    a_word_r[1] <= in_word.channel_word_1;
    a_word_r[2] <= in_word.channel_word_2;
    a_word_r[3] <= in_word.channel_word_3;
    a_type_r    <= type_r;
    a_order_r   <= order_r;
    b_type_r    <= a_type_r;
    b_order_r   <= a_order_r;
    c_type_r    <= b_type_r;
    c_order_r   <= b_order_r;
  end

  for (genvar i = 0; i < 4; i++) begin : g_ch
    scale_t      sc;
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [1:0]  cls;
    logic        bh;
    logic [4:0]  lsb;
    logic [39:0] shp;
    logic        guard;
    logic        sticky;
    logic [24:0] q;

    // classify the clamped float and multiply the significand
    always_comb begin
      sc  = scale_of(a_type_r, a_order_r, 2'(i));
      sgn = a_word_r[i][31];
      ex  = a_word_r[i][30:23];
      man = a_word_r[i][22:0];
      if (ex == 8'hFF && man != 23'd0) cls = CLS_ZERO;       // NaN
      else if (sgn && !sc.snorm) cls = CLS_ZERO;
      else if (ex == 8'd0) cls = CLS_ZERO;                    // no integer part
      else if (ex >= 8'd127) cls = CLS_FULL;                  // clamp to +-1
      else cls = CLS_CALC;
    end

    always_ff @(posedge clk) begin
      b_word_r[i]  <= a_word_r[i];
      b_prod_r[i]  <= 40'({1'b1, man}) * 40'(sc.scale);
      b_exp_r[i]   <= ex;
      b_cls_r[i]   <= cls;
      b_neg_r[i]   <= sgn;
      b_half_r[i]  <= half_of(a_word_r[i]);
      b_scale_r[i] <= sc.scale;
      b_lg_r[i]    <= sc.lg;
    end

    // round the product to a 24-bit significand, nearest even
    always_comb begin
      shp    = b_prod_r[i] >> (5'd24 + 5'(b_lg_r[i]));
      bh     = shp[0];
      lsb    = bh ? 5'(b_lg_r[i]) + 5'd1 : 5'(b_lg_r[i]);
      shp    = b_prod_r[i] >> (lsb - 5'd1);
      guard  = shp[0];
      sticky = |(b_prod_r[i] & ((40'd1 << (lsb - 5'd1)) - 40'd1));
      shp    = b_prod_r[i] >> lsb;
      q      = shp[24:0] + 25'(guard && (sticky || shp[0]));
    end

    always_ff @(posedge clk) begin
      c_word_r[i]  <= b_word_r[i];
      c_q_r[i]     <= q;
      c_sh_r[i]    <= 9'd150 - {1'b0, b_exp_r[i]} - 9'(lsb);
      c_cls_r[i]   <= b_cls_r[i];
      c_neg_r[i]   <= b_neg_r[i];
      c_half_r[i]  <= b_half_r[i];
      c_scale_r[i] <= b_scale_r[i];
    end
  end

  // output stage: truncate toward zero, pick per type, place bytes
  logic [31:0] norm [4];
  logic [31:0] chv  [4];
  logic [31:0] pk;
  logic [24:0] trunc [4];
  logic [15:0] mag  [4];
  logic [127:0] bytes;
  fmt_t        fmt;

  always_comb begin
    fmt = decode_fmt(c_type_r, c_order_r);
    for (int i = 0; i < 4; i++) begin
      trunc[i] = c_q_r[i] >> c_sh_r[i];
      if (c_cls_r[i] == CLS_FULL) mag[i] = c_scale_r[i];
      else if (c_cls_r[i] == CLS_CALC && c_sh_r[i] < 9'd25) mag[i] = trunc[i][15:0];
      else mag[i] = 16'd0;
      norm[i] = c_neg_r[i] ? 32'd0 - {16'd0, mag[i]} : {16'd0, mag[i]};
      case (c_type_r)
        TYPE_UNORM8, TYPE_UNORM16, TYPE_SNORM8, TYPE_SNORM16: chv[i] = norm[i];
        TYPE_HALF: chv[i] = {16'd0, c_half_r[i]};
        default:   chv[i] = c_word_r[i];
      endcase
    end
    case (c_type_r)
      TYPE_P565: pk = (norm[0] << 11) | (norm[1] << 5) | norm[2];
      TYPE_P555: pk = (norm[0] << 10) | (norm[1] << 5) | norm[2];
      default: begin
        if (c_order_r == ORDER_P2) begin
          pk = (norm[0] << 22) | (norm[1] << 12) | (norm[2] << 2) | norm[3];
        end else begin
          pk = (norm[0] << 20) | (norm[1] << 10) | norm[2];
        end
      end
    endcase
    if (c_type_r >= TYPE_P565) begin
      chv[0] = pk;
    end else if (c_order_r == ORDER_BGRA) begin
      chv[0] = chv[2];
      chv[2] = (c_type_r == TYPE_HALF) ? {16'd0, c_half_r[0]} :
               (c_type_r >= TYPE_UNORM8) ? norm[0] : c_word_r[0];
    end
    // drop channels past the count
    for (int i = 0; i < 4; i++) begin
      if (3'(i) >= fmt.nch) chv[i] = 32'd0;
    end
    case (fmt.csize)
      3'd1:    bytes = {96'd0, chv[3][7:0], chv[2][7:0], chv[1][7:0], chv[0][7:0]};
      3'd2:    bytes = {64'd0, chv[3][15:0], chv[2][15:0], chv[1][15:0], chv[0][15:0]};
      default: bytes = {chv[3], chv[2], chv[1], chv[0]};
    endcase
    if (fmt.csize == 3'd2 && c_type_r >= TYPE_P565) bytes[127:16] = '0;
    if (fmt.bad) bytes = '0;
    out_nxt.pattern_low   = bytes[63:0];
    out_nxt.pattern_high  = bytes[127:64];
    out_nxt.pattern_bytes = fmt.nbytes;
    out_nxt.bad_format    = fmt.bad;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

`include "fill_color_format_packer_core_assert.svh"

  `FCP_ASSERT_LAT(a_latency, clk, rst_n, start && !busy, 4, out_valid,
    "result missing four cycles after accept")
  `FCP_ASSERT(a_bad_zero, clk, rst_n,
    !(out_valid && out_result.bad_format) ||
    (out_result.pattern_low == 64'd0 && out_result.pattern_high == 64'd0 &&
     out_result.pattern_bytes == 5'd1),
    "bad format result not cleared")
  `FCP_ASSERT(a_size_range, clk, rst_n,
    !out_valid || (out_result.pattern_bytes != 5'd0 && out_result.pattern_bytes <= 5'd16),
    "pixel size out of range")
  `FCP_ASSERT(a_high_zero, clk, rst_n,
    !out_valid || out_result.pattern_bytes > 5'd8 || out_result.pattern_high == 64'd0,
    "bytes beyond pixel size not zero")

endmodule
`default_nettype wire
